[src/charset_bytes_to_ucs2_decoder_assert.svh]
// Assertion macros for the charset decoder; clocked on clk, quiet in reset.
`ifndef CHARSET_BYTES_TO_UCS2_DECODER_ASSERT_SVH
`define CHARSET_BYTES_TO_UCS2_DECODER_ASSERT_SVH

// plain invariant
`define CBU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication in the same cycle
`define CBU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[src/cbu_pkg.sv]
package cbu_pkg;

  localparam logic [1:0] MODE_LATIN1  = 2'd0;
  localparam logic [1:0] MODE_UTF8    = 2'd1;
  localparam logic [1:0] MODE_UTF16BE = 2'd2;
  localparam logic [1:0] MODE_UTF16LE = 2'd3;

  localparam logic KIND_UNIT = 1'b0;
  localparam logic KIND_TAIL = 1'b1;

  localparam logic [15:0] BAD_UNIT = 16'hFFFD;

  localparam logic REG_CHARSET_MODE = 1'b0;

  localparam int QUEUE_DEPTH = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_chunk;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] code_unit;
    logic [1:0]  tail_bytes;
    logic        last_of_run;
  } out_word_t;

  // results produced by one byte, at most two
  typedef struct packed {
    logic [1:0] count;
    out_word_t  r0;
    out_word_t  r1;
  } dec_out_t;

  function automatic out_word_t mk_word(logic kind, logic [15:0] unit, logic [1:0] tail);
    out_word_t w;
    w.result_kind = kind;
    w.code_unit   = unit;
    w.tail_bytes  = tail;
    w.last_of_run = 1'b0;
    return w;
  endfunction

endpackage

[src/cbu_decode.sv]
module cbu_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic [1:0]          mode,
  input  logic                word_valid,
  input  cbu_pkg::in_word_t   word,
  output cbu_pkg::dec_out_t   dec
);

  logic [2:0]  expected_length, expected_length_next;
  logic [1:0]  held_count, held_count_next;
  logic [15:0] partial_value, partial_value_next;
  logic [7:0]  pending_first_byte, pending_first_byte_next;
  logic        first_byte_held, first_byte_held_next;

  cbu_pkg::out_word_t res [2];
  logic [1:0]  n;
  logic        fresh;
  logic [2:0]  held_inc;
  logic [15:0] part_inc;
  logic [2:0]  len;
  logic [15:0] part_lead;
  logic [7:0]  b;
  logic        eoc;

  assign b   = word.data_byte;
  assign eoc = word.end_of_chunk;
  assign held_inc = {1'b0, held_count} + 3'd1;
  assign part_inc = {partial_value[9:0], b[5:0]};

  always_comb begin
    expected_length_next    = expected_length;
    held_count_next         = held_count;
    partial_value_next      = partial_value;
    pending_first_byte_next = pending_first_byte;
    first_byte_held_next    = first_byte_held;
    res[0] = cbu_pkg::mk_word(cbu_pkg::KIND_UNIT, 16'd0, 2'd0);
    res[1] = cbu_pkg::mk_word(cbu_pkg::KIND_UNIT, 16'd0, 2'd0);
    n      = 2'd0;
    fresh  = 1'b0;
    len       = 3'd0;
    part_lead = 16'd0;

    if (word_valid) begin
      if (mode == cbu_pkg::MODE_UTF8 && expected_length != 3'd0) begin
        if (b[7:6] == 2'b10) begin
          if (held_inc >= expected_length) begin
            res[n[0]] = cbu_pkg::mk_word(cbu_pkg::KIND_UNIT,
              (expected_length == 3'd4) ? cbu_pkg::BAD_UNIT : part_inc, 2'd0);
            n = n + 2'd1;
            expected_length_next = 3'd0;
            held_count_next      = 2'd0;
            partial_value_next   = 16'd0;
          end else if (eoc) begin
            res[n[0]] = cbu_pkg::mk_word(cbu_pkg::KIND_TAIL, 16'd0, held_inc[1:0]);
            n = n + 2'd1;
            expected_length_next = 3'd0;
            held_count_next      = 2'd0;
            partial_value_next   = 16'd0;
          end else begin
            held_count_next    = held_inc[1:0];
            partial_value_next = part_inc;
          end
        end else begin
          // sequence cut short: flag it, then take this byte afresh
          res[n[0]] = cbu_pkg::mk_word(cbu_pkg::KIND_UNIT, cbu_pkg::BAD_UNIT, 2'd0);
          n = n + 2'd1;
          expected_length_next = 3'd0;
          held_count_next      = 2'd0;
          partial_value_next   = 16'd0;
          fresh = 1'b1;
        end
      end else begin
        fresh = 1'b1;
      end

      if (fresh) begin
        if (mode == cbu_pkg::MODE_LATIN1) begin
          res[n[0]] = cbu_pkg::mk_word(cbu_pkg::KIND_UNIT, {8'd0, b}, 2'd0);
          n = n + 2'd1;
        end else if (mode == cbu_pkg::MODE_UTF16BE || mode == cbu_pkg::MODE_UTF16LE) begin
          if (first_byte_held) begin
            res[n[0]] = cbu_pkg::mk_word(cbu_pkg::KIND_UNIT,
              (mode == cbu_pkg::MODE_UTF16BE) ? {pending_first_byte, b}
                                              : {b, pending_first_byte}, 2'd0);
            n = n + 2'd1;
            pending_first_byte_next = 8'd0;
            first_byte_held_next    = 1'b0;
          end else if (eoc) begin
            res[n[0]] = cbu_pkg::mk_word(cbu_pkg::KIND_TAIL, 16'd0, 2'd1);
            n = n + 2'd1;
          end else begin
            pending_first_byte_next = b;
            first_byte_held_next    = 1'b1;
          end
        end else begin
          if (!b[7]) begin
            res[n[0]] = cbu_pkg::mk_word(cbu_pkg::KIND_UNIT, {8'd0, b}, 2'd0);
            n = n + 2'd1;
          end else if (b[7:5] == 3'b110) begin
            len       = 3'd2;
            part_lead = {11'd0, b[4:0]};
          end else if (b[7:4] == 4'b1110) begin
            len       = 3'd3;
            part_lead = {12'd0, b[3:0]};
          end else if (b[7:3] == 5'b11110) begin
            len       = 3'd4;
            part_lead = 16'd0;
          end else begin
            res[n[0]] = cbu_pkg::mk_word(cbu_pkg::KIND_UNIT, cbu_pkg::BAD_UNIT, 2'd0);
            n = n + 2'd1;
          end
          if (len != 3'd0) begin
            if (eoc) begin
              res[n[0]] = cbu_pkg::mk_word(cbu_pkg::KIND_TAIL, 16'd0, 2'd1);
              n = n + 2'd1;
            end else begin
              expected_length_next = len;
              held_count_next      = 2'd1;
              partial_value_next   = part_lead;
            end
          end
        end
      end

      if (n == 2'd1) begin
        res[0].last_of_run = 1'b1;
      end else if (n == 2'd2) begin
        res[1].last_of_run = 1'b1;
      end
    end
  end

  assign dec.count = n;
  assign dec.r0    = res[0];
  assign dec.r1    = res[1];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      expected_length    <= 3'd0;
      held_count         <= 2'd0;
      partial_value      <= 16'd0;
      pending_first_byte <= 8'd0;
      first_byte_held    <= 1'b0;
    end else begin
      expected_length    <= expected_length_next;
      held_count         <= held_count_next;
      partial_value      <= partial_value_next;
      pending_first_byte <= pending_first_byte_next;
      first_byte_held    <= first_byte_held_next;
    end
  end

endmodule

[src/charset_bytes_to_ucs2_decoder.sv]
// Path: a byte accepted on the input is registered in s1_word, decoded combinationally
//   and written into the result queue, and its first result is offered from the queue head.
// Throughput: one byte per cycle while in_stall is low; a byte giving two results is
//   absorbed by the QDEPTH-entry result queue. in_stall rises when the queue may overflow.
// Reset: synchronous, clears charset_mode to Latin-1, all sequence state and the queue.
module charset_bytes_to_ucs2_decoder #(
  parameter int QDEPTH = cbu_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cbu_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cbu_pkg::out_word_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  logic [1:0]         charset_mode;
  logic               cfg_write;
  logic               mode_write;

  logic               s1_valid;
  cbu_pkg::in_word_t  s1_word;
  cbu_pkg::dec_out_t  dec;

  cbu_pkg::out_word_t q [QDEPTH];
  logic [PW-1:0]      wr_ptr, rd_ptr;
  logic [CW-1:0]      q_count, q_count_next;
  logic               pop;
  logic               in_take;
  logic [CW:0]        committed;

  // config port
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign mode_write = cfg_write && (paddr[2] == cbu_pkg::REG_CHARSET_MODE);
  assign prdata     = (paddr[2] == cbu_pkg::REG_CHARSET_MODE) ? {30'd0, charset_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      charset_mode <= cbu_pkg::MODE_LATIN1;
    end else if (mode_write) begin
      charset_mode <= pwdata[1:0];
    end
  end

  // room for the word in flight and the incoming one, two results each
  assign committed = {1'b0, q_count} + (s1_valid ? (CW+1)'(2) : (CW+1)'(0));
  assign in_stall  = committed > (CW+1)'(QDEPTH - 2);
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word <= in_data;
    end
  end

  cbu_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .clear      (mode_write),
    .mode       (charset_mode),
    .word_valid (s1_valid),
    .word       (s1_word),
    .dec        (dec)
  );

  // result queue
  assign out_valid = q_count != '0;
  assign out_data  = q[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign q_count_next = q_count + CW'(dec.count) - (pop ? CW'(1) : CW'(0));

  always_ff @(posedge clk) begin
    if (dec.count != 2'd0) begin
      q[wr_ptr] <= dec.r0;
    end
    if (dec.count == 2'd2) begin
      q[wr_ptr + PW'(1)] <= dec.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + PW'(dec.count);
      q_count <= q_count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
    end
  end

`include "charset_bytes_to_ucs2_decoder_assert.svh"

  `CBU_ASSERT(a_queue_bound, q_count <= CW'(QDEPTH), "result queue overflow")
  `CBU_ASSERT_IMP(a_room_for_word, s1_valid, q_count <= CW'(QDEPTH - 2), "no room for decoded word")
  `CBU_ASSERT_IMP(a_latin1_single, s1_valid && charset_mode == cbu_pkg::MODE_LATIN1, dec.count == 2'd1, "latin1 byte must give one result")
  `CBU_ASSERT_IMP(a_idle_no_push, !s1_valid, dec.count == 2'd0, "result pushed without a word")

endmodule
